[rtl/ncpd_pkg.sv]
// ncpd_pkg: shared types and constants for the nearest-centroid distance core.
// No dependencies.
package ncpd_pkg;

	localparam logic [1:0] CMD_WRITE_COMP  = 2'd0;
	localparam logic [1:0] CMD_WRITE_COUNT = 2'd1;
	localparam logic [1:0] CMD_CLASSIFY    = 2'd2;

	// Register byte address of gate_multiplier
	localparam logic [1:0] REG_GATE_ADDR   = 2'd0;

	localparam logic [7:0]  GATE_RESET     = 8'd40;
	localparam logic [12:0] DIST_SATURATED = 13'd8191;
	localparam int          SUM_W          = 26;
	localparam int          ROOT_W         = 13;

	// Decoded classify job handed from front to back.
	typedef struct packed {
		logic        no_model;
		logic [3:0]  count;
		logic [11:0] s0;
		logic [11:0] s1;
		logic [11:0] s2;
	} job_t;

endpackage

[rtl/ncpd_ram.sv]
// ncpd_ram: generic single-port write, single-port read RAM, registered read.
// No dependencies.
module ncpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/ncpd_isqrt.sv]
// ncpd_isqrt: iterative truncated square root, one result bit per cycle.
// Depends on ncpd_pkg.
module ncpd_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ncpd_pkg::SUM_W-1:0] value,
	output logic                       busy,
	output logic                       done,
	output logic [ncpd_pkg::ROOT_W-1:0] root
);
	localparam int RW = ncpd_pkg::ROOT_W;
	localparam int VW = 2 * RW;

	logic [VW-1:0]          rem_q;
	logic [VW-1:0]          val_q;
	logic [RW-1:0]          root_q;
	logic [$clog2(RW+1)-1:0] cnt_q;
	logic [VW+1:0]          trial;
	logic [VW+1:0]          rem_sh;

	// Restoring digit step: bring down two bits, try 4r+1.
	assign rem_sh = {rem_q, val_q[VW-1 -: 2]};
	assign trial  = rem_sh - {{(VW-RW){1'b0}}, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				cnt_q <= ($clog2(RW+1))'(RW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ($clog2(RW+1))'(1)) begin
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= VW'(value);
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			val_q <= {val_q[VW-3:0], 2'b00};
			if (!trial[VW+1]) begin
				rem_q  <= trial[VW-1:0];
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[VW-1:0];
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign root = root_q;
endmodule

[rtl/ncpd_front.sv]
// ncpd_front: accepts items, performs model writes, reads counts, queues classify jobs.
// Depends on ncpd_pkg and ncpd_ram.
module ncpd_front #(
	parameter int PIXEL_COUNT    = 32768,
	parameter int MAX_COMPONENTS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            command,
	input  logic [14:0]           pixel_index,
	input  logic [2:0]            component_index,
	input  logic [3:0]            component_count,
	input  logic [11:0]           center_first,
	input  logic [11:0]           center_second,
	input  logic [11:0]           center_third,
	input  logic [15:0]           spread,
	input  logic [7:0]            sample_first,
	input  logic [7:0]            sample_second,
	input  logic [7:0]            sample_third,
	// component write port toward the model memories
	output logic                  comp_we,
	output logic [$clog2(PIXEL_COUNT*MAX_COMPONENTS)-1:0] comp_waddr,
	output logic [51:0]           comp_wdata,
	// back end still reading the model
	input  logic                  walk_active,
	// job queue output
	output logic                  job_valid,
	input  logic                  job_take,
	output ncpd_pkg::job_t        job,
	output logic [14:0]           job_pixel
);
	localparam int PW  = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
	localparam int CW  = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
	localparam int EW  = $clog2(PIXEL_COUNT*MAX_COMPONENTS);
	localparam int QD  = 2;

	logic accept, pix_ok, is_cls;
	logic [3:0] cnt_sat, cnt_rd;
	logic [PW-1:0] pix_a;

	// Stage 1: classify waiting for its count read.
	logic                 v_s1;
	ncpd_pkg::job_t       job_s1;
	logic [14:0]          pix_s1;

	// Two-entry queue.
	ncpd_pkg::job_t q_job_q [QD];
	logic [14:0]    q_pix_q [QD];
	logic [1:0]     q_cnt_q;
	logic           q_wr_q, q_rd_q;
	logic           push, pop;
	ncpd_pkg::job_t job_m;

	assign pix_ok  = 32'(pixel_index) < PIXEL_COUNT;
	assign pix_a   = PW'(pixel_index);
	assign is_cls  = command == ncpd_pkg::CMD_CLASSIFY;
	// stall while queue cannot absorb an in-flight classify plus this one;
	// a component write also waits until no classify still has to read the model
	assign in_stall = ((q_cnt_q + {1'b0, v_s1}) >= 2'(QD))
		|| (command == ncpd_pkg::CMD_WRITE_COMP
			&& (v_s1 || q_cnt_q != '0 || walk_active));
	assign accept  = in_valid && !in_stall;
	assign cnt_sat = (32'(component_count) > MAX_COMPONENTS) ? 4'(MAX_COMPONENTS)
		: component_count;

	// Component write decode.
	assign comp_we    = accept && command == ncpd_pkg::CMD_WRITE_COMP && pix_ok
		&& 32'(component_index) < MAX_COMPONENTS;
	assign comp_waddr = EW'(32'(pixel_index) * MAX_COMPONENTS + 32'(component_index));
	assign comp_wdata = {center_first, center_second, center_third, spread};

	ncpd_ram #(.WIDTH(4), .DEPTH(PIXEL_COUNT)) u_count (
		.clk(clk),
		.we(accept && command == ncpd_pkg::CMD_WRITE_COUNT && pix_ok),
		.waddr(pix_a), .wdata(cnt_sat), .raddr(pix_a), .rdata(cnt_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept && is_cls;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1.no_model <= !pix_ok;
			job_s1.count    <= '0;
			job_s1.s0       <= {sample_first, 4'b0};
			job_s1.s1       <= {sample_second, 4'b0};
			job_s1.s2       <= {sample_third, 4'b0};
			pix_s1          <= pixel_index;
		end
	end

	// Queue push with count merged in.
	assign push = v_s1;
	assign pop  = job_take && q_cnt_q != '0;

	always_comb begin
		job_m          = job_s1;
		job_m.count    = job_s1.no_model ? 4'd0 : cnt_rd;
		job_m.no_model = job_s1.no_model || cnt_rd == 4'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_cnt_q <= '0;
			q_wr_q  <= 1'b0;
			q_rd_q  <= 1'b0;
		end else begin
			if (push) q_wr_q <= !q_wr_q;
			if (pop)  q_rd_q <= !q_rd_q;
			q_cnt_q <= q_cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_job_q[q_wr_q] <= job_m;
			q_pix_q[q_wr_q] <= pix_s1;
		end
	end

	assign job_valid = q_cnt_q != '0;
	assign job       = q_job_q[q_rd_q];
	assign job_pixel = q_pix_q[q_rd_q];

	property p_no_overflow;
		@(posedge clk) disable iff (!arst_n) q_cnt_q <= 2'(QD);
	endproperty
	a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");
	a_push_space: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> q_cnt_q < 2'(QD) || pop) else $error("push into full queue");
	a_cls_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_cls) |=> v_s1) else $error("classify lost");
endmodule

[rtl/ncpd_back.sv]
// ncpd_back: walks a pixel's components, keeps min distance and max spread,
// takes the square root and gates it. Depends on ncpd_pkg, ncpd_ram, ncpd_isqrt.
module ncpd_back #(
	parameter int PIXEL_COUNT    = 32768,
	parameter int MAX_COMPONENTS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            gate,
	input  logic                  comp_we,
	input  logic [$clog2(PIXEL_COUNT*MAX_COMPONENTS)-1:0] comp_waddr,
	input  logic [51:0]           comp_wdata,
	output logic                  walk_active,
	input  logic                  job_valid,
	output logic                  job_take,
	input  ncpd_pkg::job_t        job,
	input  logic [14:0]           job_pixel,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [12:0]           gated_distance,
	output logic                  foreground,
	output logic                  no_model
);
	localparam int EW = $clog2(PIXEL_COUNT*MAX_COMPONENTS);
	localparam int SW = ncpd_pkg::SUM_W;

	typedef enum logic [2:0] {ST_IDLE, ST_WALK, ST_ROOT, ST_GATE, ST_OUT} state_t;
	state_t state_q;

	ncpd_pkg::job_t job_q;
	logic [EW-1:0]  base_q;
	logic [3:0]     issue_q;
	logic [3:0]     recv_q;
	logic           rd_v_s1, rd_v_s2;
	logic [51:0]    rdata;
	logic [SW-1:0]  best_q;
	logic [15:0]    maxsp_q;
	logic [23:0]    sq0_s2, sq1_s2, sq2_s2;
	logic [15:0]    sp_s2;
	logic [SW-1:0]  sum;
	logic           root_start, root_busy, root_done;
	logic [12:0]    root;
	logic [12:0]    dist_q;
	logic [23:0]    lhs_q, rhs_q;

	function automatic logic [11:0] absdiff(input logic [11:0] a, input logic [11:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	ncpd_ram #(.WIDTH(52), .DEPTH(PIXEL_COUNT*MAX_COMPONENTS)) u_model (
		.clk(clk), .we(comp_we), .waddr(comp_waddr), .wdata(comp_wdata),
		.raddr(base_q + EW'(issue_q)), .rdata(rdata)
	);

	// Per-entry squared differences, registered before the sum.
	always_ff @(posedge clk) begin
		sq0_s2 <= absdiff(job_q.s0, rdata[51:40]) * absdiff(job_q.s0, rdata[51:40]);
		sq1_s2 <= absdiff(job_q.s1, rdata[39:28]) * absdiff(job_q.s1, rdata[39:28]);
		sq2_s2 <= absdiff(job_q.s2, rdata[27:16]) * absdiff(job_q.s2, rdata[27:16]);
		sp_s2  <= rdata[15:0];
	end
	assign sum = SW'(sq0_s2) + SW'(sq1_s2) + SW'(sq2_s2);

	assign job_take    = state_q == ST_IDLE;
	assign walk_active = state_q == ST_WALK;
	assign root_start  = state_q == ST_WALK && recv_q == job_q.count && !rd_v_s1 && !rd_v_s2;

	ncpd_isqrt u_root (
		.clk(clk), .arst_n(arst_n), .start(root_start), .value(best_q),
		.busy(root_busy), .done(root_done), .root(root)
	);

	// Sequencer with registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
			issue_q   <= '0;
			recv_q    <= '0;
			rd_v_s1   <= 1'b0;
			rd_v_s2   <= 1'b0;
		end else begin
			rd_v_s1 <= state_q == ST_WALK && issue_q != job_q.count;
			rd_v_s2 <= rd_v_s1;
			if (state_q == ST_OUT && (!out_valid || !out_stall)) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						issue_q <= '0;
						recv_q  <= '0;
						state_q <= job.no_model ? ST_OUT : ST_WALK;
					end
				end
				ST_WALK: begin
					if (issue_q != job_q.count) issue_q <= issue_q + 1'b1;
					if (rd_v_s2) recv_q <= recv_q + 1'b1;
					if (root_start) state_q <= ST_ROOT;
				end
				ST_ROOT: if (root_done) state_q <= ST_GATE;
				ST_GATE: state_q <= ST_OUT;
				ST_OUT: begin
					if (!out_valid || !out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && job_valid) begin
			job_q   <= job;
			base_q  <= EW'(32'(job_pixel) * MAX_COMPONENTS);
			best_q  <= '1;
			maxsp_q <= '0;
		end
		if (state_q == ST_WALK && rd_v_s2) begin
			if (sum < best_q) best_q <= sum;
			if (sp_s2 > maxsp_q) maxsp_q <= sp_s2;
		end
		if (root_done) begin
			dist_q <= root;
			lhs_q  <= {7'd0, root, 4'd0};
			rhs_q  <= gate * maxsp_q;
		end
		if (state_q == ST_OUT && (!out_valid || !out_stall)) begin
			if (job_q.no_model) begin
				gated_distance <= ncpd_pkg::DIST_SATURATED;
				foreground     <= 1'b1;
				no_model       <= 1'b1;
			end else begin
				foreground     <= lhs_q > rhs_q;
				gated_distance <= (lhs_q > rhs_q) ? dist_q : '0;
				no_model       <= 1'b0;
			end
		end
	end

	a_root_idle: assert property (@(posedge clk) disable iff (!arst_n)
		root_start |-> !root_busy) else $error("root unit restarted while busy");
	a_recv_le: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> recv_q <= issue_q) else $error("receive ahead of issue");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(gated_distance))
		else $error("result dropped");
endmodule

[rtl/nearest_centroid_pixel_distance_core.sv]
// A classify result passes the queue hand-off, the component walk, the 13-step root
// and the gate; a pixel with no components goes straight from the queue to the output.
// Classifies are paced by the walk and the serial root; the queue still accepts new
// ones meanwhile. Other beats pass while the queue has room; a component write waits
// until no in-flight, queued or walking classify still reads the model.
// Reset: arst_n clears control, gate_multiplier = 2.5; model memories are not cleared.
module nearest_centroid_pixel_distance_core #(
	parameter int PIXEL_COUNT    = 32768,
	parameter int MAX_COMPONENTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [14:0] pixel_index,
	input  logic [2:0]  component_index,
	input  logic [3:0]  component_count,
	input  logic [11:0] center_first,
	input  logic [11:0] center_second,
	input  logic [11:0] center_third,
	input  logic [15:0] spread,
	input  logic [7:0]  sample_first,
	input  logic [7:0]  sample_second,
	input  logic [7:0]  sample_third,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [12:0] gated_distance,
	output logic        foreground,
	output logic        no_model
);
	localparam int EW = $clog2(PIXEL_COUNT*MAX_COMPONENTS);

	logic [7:0]     gate_q;
	logic           comp_we, job_valid, job_take, walk_active;
	logic [EW-1:0]  comp_waddr;
	logic [51:0]    comp_wdata;
	ncpd_pkg::job_t job;
	logic [14:0]    job_pixel;

	// Register port.
	assign pready = 1'b1;
	assign prdata = (paddr == ncpd_pkg::REG_GATE_ADDR) ? {24'd0, gate_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q <= ncpd_pkg::GATE_RESET;
		end else if (psel && penable && pwrite && paddr == ncpd_pkg::REG_GATE_ADDR) begin
			gate_q <= pwdata[7:0];
		end
	end

	ncpd_front #(.PIXEL_COUNT(PIXEL_COUNT), .MAX_COMPONENTS(MAX_COMPONENTS)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .command, .pixel_index, .component_index,
		.component_count, .center_first, .center_second, .center_third, .spread,
		.sample_first, .sample_second, .sample_third, .comp_we, .comp_waddr,
		.comp_wdata, .walk_active, .job_valid, .job_take, .job, .job_pixel
	);

	ncpd_back #(.PIXEL_COUNT(PIXEL_COUNT), .MAX_COMPONENTS(MAX_COMPONENTS)) u_back (
		.clk, .arst_n, .gate(gate_q), .comp_we, .comp_waddr, .comp_wdata,
		.walk_active, .job_valid, .job_take, .job, .job_pixel, .out_valid, .out_stall,
		.gated_distance, .foreground, .no_model
	);
endmodule

[tb/nearest_centroid_pixel_distance_core_test.sv]
// Self-checking testbench for nearest_centroid_pixel_distance_core: loads per-pixel models,
// classifies samples, and checks every result beat against its own predictor.
// Depends on ncpd_pkg and the core RTL.
module nearest_centroid_pixel_distance_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_NONE_CODE = 2'd3;
	localparam int COMP_MAX      = 8;
	localparam int SETTLE_CYCLES = 40;
	localparam int IDLE_LIMIT    = 5000;
	localparam int POOL_SIZE     = 20;
	localparam int RANDOM_ITEMS  = 1150;

	typedef struct {
		logic [1:0]  cmd;
		logic [14:0] pix;
		logic [2:0]  comp;
		logic [3:0]  cnt;
		logic [11:0] c0, c1, c2;
		logic [15:0] spr;
		logic [7:0]  s0, s1, s2;
	} beat_t;

	typedef struct {
		logic [12:0] gdist;
		logic        fg;
		logic        nm;
	} distance_t;

	// Background model mirror and queue of pending classify answers
	class distance_scoreboard;
		logic [11:0] cen0[int], cen1[int], cen2[int];
		logic [15:0] spr_mem[int];
		logic [3:0]  cnt_mem[int];
		logic [7:0]  gate;
		distance_t   pending_q[$];

		function new();
			gate = ncpd_pkg::GATE_RESET;
		endfunction

		static function int unsigned isqrt(int unsigned v);
			int unsigned root, b;
			root = 0;
			b = 32'h4000_0000;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= root + b) begin
					v -= root + b;
					root = (root >> 1) + b;
				end else begin
					root >>= 1;
				end
				b >>= 2;
			end
			return root;
		endfunction

		static function int unsigned sqd(int unsigned a, int unsigned b);
			int unsigned d;
			d = (a > b) ? a - b : b - a;
			return d * d;
		endfunction

		function void note_input(beat_t it);
			int e, n;
			int unsigned best, maxs, sum, root_val, a0, a1, a2;
			distance_t r;
			e = int'(it.pix) * COMP_MAX + int'(it.comp);
			case (it.cmd)
				ncpd_pkg::CMD_WRITE_COMP: begin
					cen0[e] = it.c0;
					cen1[e] = it.c1;
					cen2[e] = it.c2;
					spr_mem[e] = it.spr;
				end
				ncpd_pkg::CMD_WRITE_COUNT: begin
					cnt_mem[it.pix] = (it.cnt > COMP_MAX) ? 4'(COMP_MAX) : it.cnt;
				end
				ncpd_pkg::CMD_CLASSIFY: begin
					n = cnt_mem[it.pix];
					if (n == 0) begin
						r.gdist = ncpd_pkg::DIST_SATURATED;
						r.fg = 1;
						r.nm = 1;
					end else begin
						a0 = {it.s0, 4'h0};
						a1 = {it.s1, 4'h0};
						a2 = {it.s2, 4'h0};
						best = 32'hFFFF_FFFF;
						maxs = 0;
						for (int i = 0; i < n; i++) begin
							e = int'(it.pix) * COMP_MAX + i;
							sum = sqd(a0, cen0[e]) + sqd(a1, cen1[e]) + sqd(a2, cen2[e]);
							if (sum < best) best = sum;
							if (spr_mem[e] > maxs) maxs = spr_mem[e];
						end
						root_val = isqrt(best);
						r.nm = 0;
						if (root_val * 16 > gate * maxs) begin
							r.gdist = (root_val > ncpd_pkg::DIST_SATURATED)
								? ncpd_pkg::DIST_SATURATED : 13'(root_val);
							r.fg = 1;
						end else begin
							r.gdist = 0;
							r.fg = 0;
						end
					end
					pending_q.insert(pending_q.size(), r);
				end
				default: ;
			endcase
		endfunction

		// Returns 1 on a mismatch, with a description in msg
		function bit check_result(logic [12:0] d, logic fg, logic nm, output string msg);
			distance_t x;
			if (pending_q.size() == 0) begin
				msg = $sformatf("unexpected result dist=%0d fg=%0d nm=%0d", d, fg, nm);
				return 1;
			end
			x = pending_q.pop_front();
			if (d !== x.gdist || fg !== x.fg || nm !== x.nm) begin
				msg = $sformatf("got dist=%0d fg=%0d nm=%0d, want dist=%0d fg=%0d nm=%0d",
					d, fg, nm, x.gdist, x.fg, x.nm);
				return 1;
			end
			return 0;
		endfunction
	endclass

	logic        clk, arst_n;
	logic        psel, penable, pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	logic        in_valid, in_stall;
	logic [1:0]  command;
	logic [14:0] pixel_index;
	logic [2:0]  component_index;
	logic [3:0]  component_count;
	logic [11:0] center_first, center_second, center_third;
	logic [15:0] spread;
	logic [7:0]  sample_first, sample_second, sample_third;
	logic        out_valid, out_stall;
	logic [12:0] gated_distance;
	logic        foreground, no_model;

	nearest_centroid_pixel_distance_core dut (.*);

	distance_scoreboard sb = new();
	int          error_count = 0;
	int          beats_sent = 0;
	int          pool[POOL_SIZE];
	logic [7:0]  comp_mask[int];
	bit          has_count[int];

	task automatic report_mismatch(string msg);
		$display("MISMATCH: %s", msg);
		error_count++;
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic bit quiet_stretch();
		return beats_sent >= 500 && beats_sent < 700;
	endfunction

	// Drive one input beat and wait until it is taken
	task automatic send_beat(beat_t it);
		int gap;
		if (!quiet_stretch() && $urandom_range(0, 99) < 26) begin
			gap = $urandom_range(1, 4);
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid        <= 1;
		command         <= it.cmd;
		pixel_index     <= it.pix;
		component_index <= it.comp;
		component_count <= it.cnt;
		center_first    <= it.c0;
		center_second   <= it.c1;
		center_third    <= it.c2;
		spread          <= it.spr;
		sample_first    <= it.s0;
		sample_second   <= it.s1;
		sample_third    <= it.s2;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		sb.note_input(it);
		if (it.cmd == ncpd_pkg::CMD_WRITE_COMP) begin
			if (!comp_mask.exists(it.pix)) comp_mask[it.pix] = 0;
			comp_mask[it.pix][it.comp] = 1;
		end
		if (it.cmd == ncpd_pkg::CMD_WRITE_COUNT) has_count[it.pix] = 1;
		if (it.cmd != CMD_NONE_CODE) beats_sent++;
	endtask

	function automatic beat_t rand_beat();
		beat_t it;
		it.cmd  = ncpd_pkg::CMD_CLASSIFY;
		it.pix  = 15'($urandom());
		it.comp = 3'($urandom());
		it.cnt  = 4'($urandom());
		it.c0   = 12'($urandom());
		it.c1   = 12'($urandom());
		it.c2   = 12'($urandom());
		it.spr  = 16'($urandom());
		it.s0   = 8'($urandom());
		it.s1   = 8'($urandom());
		it.s2   = 8'($urandom());
		return it;
	endfunction

	// Number of components written contiguously from slot 0
	function automatic int prefix_len(int p);
		int k;
		k = 0;
		if (comp_mask.exists(p))
			while (k < COMP_MAX && comp_mask[p][k]) k++;
		return k;
	endfunction

	task automatic write_legal_count(int p);
		beat_t it;
		int k;
		it = rand_beat();
		it.cmd = ncpd_pkg::CMD_WRITE_COUNT;
		it.pix = 15'(p);
		k = prefix_len(p);
		if (k == COMP_MAX && $urandom_range(0, 1)) it.cnt = 4'($urandom_range(COMP_MAX, 15));
		else it.cnt = 4'($urandom_range(0, k));
		send_beat(it);
	endtask

	task automatic classify_pixel(int p);
		beat_t it;
		int e;
		it = rand_beat();
		it.pix = 15'(p);
		e = p * COMP_MAX;
		// Aim near the first centroid at times so the gate can close
		if (sb.cen0.exists(e) && $urandom_range(0, 1)) begin
			it.s0 = 8'(sb.cen0[e] >> 4) ^ 8'($urandom_range(0, 3));
			it.s1 = 8'(sb.cen1[e] >> 4) ^ 8'($urandom_range(0, 3));
			it.s2 = 8'(sb.cen2[e] >> 4) ^ 8'($urandom_range(0, 3));
		end
		send_beat(it);
	endtask

	task automatic random_phase(int beats);
		beat_t it;
		int stop, p, k, r;
		stop = beats_sent + beats;
		while (beats_sent < stop) begin
			p = pool[$urandom_range(0, POOL_SIZE - 1)];
			r = $urandom_range(0, 99);
			if (r < 45) begin
				k = $urandom_range(1, COMP_MAX);
				for (int i = 0; i < k; i++) begin
					it = rand_beat();
					it.cmd = ncpd_pkg::CMD_WRITE_COMP;
					it.pix = 15'(p);
					it.comp = 3'(i);
					if ($urandom_range(0, 1)) it.spr = 16'($urandom_range(0, 255));
					send_beat(it);
				end
				write_legal_count(p);
				repeat ($urandom_range(1, 3)) classify_pixel(p);
			end else if (r < 80) begin
				if (!has_count.exists(p)) write_legal_count(p);
				classify_pixel(p);
			end else if (r < 90) begin
				it = rand_beat();
				it.cmd = ncpd_pkg::CMD_WRITE_COMP;
				it.pix = 15'(p);
				send_beat(it);
			end else if (r < 95) begin
				write_legal_count(p);
			end else begin
				it = rand_beat();
				it.cmd = CMD_NONE_CODE;
				send_beat(it);
			end
		end
	endtask

	// APB register write; only called while the core is idle
	task automatic write_gate(logic [7:0] g);
		psel    <= 1;
		pwrite  <= 1;
		paddr   <= ncpd_pkg::REG_GATE_ADDR;
		pwdata  <= {24'h0, g};
		penable <= 0;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel    <= 0;
		penable <= 0;
		pwrite  <= 0;
		sb.gate = g;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic directed_part();
		beat_t it;
		// Corner pixel with no components
		it = rand_beat();
		it.cmd = ncpd_pkg::CMD_WRITE_COUNT; it.pix = 15'h7FFF; it.cnt = 0;
		send_beat(it);
		it.cmd = ncpd_pkg::CMD_CLASSIFY;
		send_beat(it);
		// Pixel 0: one all-zero component
		it = rand_beat();
		it.cmd = ncpd_pkg::CMD_WRITE_COMP; it.pix = 0; it.comp = 0;
		it.c0 = 0; it.c1 = 0; it.c2 = 0; it.spr = 0;
		send_beat(it);
		it.cmd = ncpd_pkg::CMD_WRITE_COUNT; it.cnt = 1;
		send_beat(it);
		it.cmd = ncpd_pkg::CMD_CLASSIFY; it.s0 = 0; it.s1 = 0; it.s2 = 0;
		send_beat(it);
		it.s0 = 8'hFF; it.s1 = 8'hFF; it.s2 = 8'hFF;
		send_beat(it);
		// Pixel 5: all slots at full scale, count saturated
		for (int i = 0; i < COMP_MAX; i++) begin
			it = rand_beat();
			it.cmd = ncpd_pkg::CMD_WRITE_COMP; it.pix = 15'd5; it.comp = 3'(i);
			it.c0 = 12'hFFF; it.c1 = 12'hFFF; it.c2 = 12'hFFF;
			it.spr = (i == 7) ? 16'hFFFF : 16'h0;
			send_beat(it);
		end
		it.cmd = ncpd_pkg::CMD_WRITE_COUNT; it.cnt = 4'hF;
		send_beat(it);
		it.cmd = ncpd_pkg::CMD_CLASSIFY; it.s0 = 0; it.s1 = 0; it.s2 = 0;
		send_beat(it);
		it.s0 = 8'hFF; it.s1 = 8'hFF; it.s2 = 8'hFF;
		send_beat(it);
		// Unused command code is dropped
		it.cmd = CMD_NONE_CODE;
		send_beat(it);
		it.cmd = ncpd_pkg::CMD_WRITE_COUNT; it.cnt = 4'(COMP_MAX);
		send_beat(it);
		it.cmd = ncpd_pkg::CMD_CLASSIFY; it.s0 = 8'h80;
		send_beat(it);
	endtask

	// Stimulus and configuration phases
	initial begin
		logic [7:0] gates[6];
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		in_valid = 0; command = 0; pixel_index = 0; component_index = 0;
		component_count = 0; center_first = 0; center_second = 0; center_third = 0;
		spread = 0; sample_first = 0; sample_second = 0; sample_third = 0;
		pool[0] = 0;
		pool[1] = 32767;
		for (int i = 2; i < POOL_SIZE; i++) pool[i] = $urandom_range(0, 32767);
		gates[0] = 8'd0;
		gates[1] = 8'd255;
		gates[2] = 8'd16;
		gates[3] = 8'($urandom());
		gates[4] = 8'd1;
		gates[5] = ncpd_pkg::GATE_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		directed_part();
		for (int g = 0; g < 6; g++) begin
			drain();
			write_gate(gates[g]);
			random_phase(RANDOM_ITEMS / 6);
		end
		drain();
		if (sb.pending_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", sb.pending_q.size()));
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Result side: random stall, one long hold-off, checks each beat
	initial begin
		int hold;
		bit held;
		string msg;
		out_stall = 0;
		hold = 0;
		held = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall && arst_n)
				if (sb.check_result(gated_distance, foreground, no_model, msg))
					report_mismatch(msg);
			if (!held && beats_sent >= 300) begin
				held = 1;
				hold = 300;
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1;
			end else begin
				out_stall <= !quiet_stretch() && $urandom_range(0, 99) < 26;
			end
		end
	end

	// Watchdog on cycles without any handshake
	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel || !arst_n)
				idle = 0;
			else
				idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

endmodule
